### rtl/a0p_pkg.sv
// Package for the AMF0 object parser: item types, parse phases and code constants.
// Depends on nothing; every other file of the parser depends on it.
package a0p_pkg;

   localparam int unsigned MAX_PAIRS = 32;

   localparam logic [7:0] MK_NUMBER  = 8'h00;
   localparam logic [7:0] MK_BOOLEAN = 8'h01;
   localparam logic [7:0] MK_STRING  = 8'h02;
   localparam logic [7:0] MK_OBJECT  = 8'h03;
   localparam logic [7:0] MK_MIXED   = 8'h08;
   localparam logic [7:0] MK_LONGSTR = 8'h0C;

   localparam logic [31:0] ARRAY_END_BYTES = 32'd3;

   localparam logic [3:0] KIND_CONTAINER = 4'd0;
   localparam logic [3:0] KIND_COUNT     = 4'd1;
   localparam logic [3:0] KIND_KEYLEN    = 4'd2;
   localparam logic [3:0] KIND_KEY       = 4'd3;
   localparam logic [3:0] KIND_VALTYPE   = 4'd4;
   localparam logic [3:0] KIND_NUMBER    = 4'd5;
   localparam logic [3:0] KIND_BOOL      = 4'd6;
   localparam logic [3:0] KIND_STRLEN    = 4'd7;
   localparam logic [3:0] KIND_STR       = 4'd8;
   localparam logic [3:0] KIND_END       = 4'd9;
   localparam logic [3:0] KIND_IGNORED   = 4'd10;

   localparam logic [2:0] VT_NONE    = 3'd0;
   localparam logic [2:0] VT_NUMBER  = 3'd1;
   localparam logic [2:0] VT_BOOLEAN = 3'd2;
   localparam logic [2:0] VT_STRING  = 3'd3;
   localparam logic [2:0] VT_LONGSTR = 3'd4;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_CONTAINER = 2'd1;
   localparam logic [1:0] ERR_VALTYPE   = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_COUNT   = 4'd1,
      PH_KEYLEN  = 4'd2,
      PH_KEY     = 4'd3,
      PH_VALTYPE = 4'd4,
      PH_NUMBER  = 4'd5,
      PH_BOOL    = 4'd6,
      PH_STRLEN  = 4'd7,
      PH_STR     = 4'd8,
      PH_END     = 4'd9
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] pair_index;
      logic [2:0]  vtype;
      logic [7:0]  data_byte;
      logic [63:0] number_bits;
      logic        boolean_value;
      logic [31:0] length;
      logic        item_done;
      logic        stored;
      logic [1:0]  error;
      logic        last;
      logic [31:0] bytes_used;
   } rsp_type;

endpackage

### rtl/a0p_req_if.sv
// Input channel of the AMF0 object parser: one stream byte per item.
// Depends on a0p_pkg for the payload type.
interface a0p_req_if;
   logic             valid;
   logic             ready;
   a0p_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/a0p_rsp_if.sv
// Result channel of the AMF0 object parser: one classified byte per item.
// Depends on a0p_pkg for the payload type.
interface a0p_rsp_if;
   logic             valid;
   logic             ready;
   a0p_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/amf0_object_parser.sv
// AMF0 object and mixed array parser: classifies one stream byte per item.
// Depends on a0p_pkg, a0p_req_if and a0p_rsp_if.
//
//   channel    direction  payload                       handshake
//   req_chan   in         in_byte, start_req            valid/ready
//   rsp_chan   out        kind ... bytes_used (rsp)     valid/ready
//
// Every accepted byte yields exactly one result item, registered and valid in the next cycle.
// A new byte is accepted in every cycle in which the result register is empty
// or is being emptied, so the sustained rate is one byte per cycle.
// The parse state and the result register sit in one stage; the next-state and
// result logic between them is a few 32-bit compares, shifts, increments and decrements.
// Synchronous reset returns the parser to idle and empties the result register.
module amf0_object_parser (
   input  logic  clock,
   input  logic  reset,
   a0p_req_if.sink   req_chan,
   a0p_rsp_if.source rsp_chan
);
   import a0p_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        container_is_array_ff, container_is_array_in;
   logic [31:0] field_remaining_ff, field_remaining_in;
   logic [31:0] length_accum_ff, length_accum_in;
   logic [63:0] number_accum_ff, number_accum_in;
   logic [31:0] pairs_left_ff, pairs_left_in;
   logic [31:0] pair_count_ff, pair_count_in;
   logic [2:0]  vtype_ff, vtype_in;
   logic [31:0] byte_total_ff, byte_total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [7:0]  b;
   logic        start;
   logic        active;
   logic        field_last;
   logic [31:0] field_dec;
   logic [31:0] len_shift;
   logic [63:0] num_shift;
   logic [31:0] pairs_dec;
   logic        do_finish;
   logic        pair_byte;

   assign req_chan.ready   = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign b          = req_chan.payload.in_byte;
   assign start      = req_chan.payload.start_req;
   assign active     = (phase_ff != PH_IDLE);
   assign field_last = (field_remaining_ff <= 32'd1);
   assign field_dec  = field_last ? 32'd0 : field_remaining_ff - 32'd1;
   assign len_shift  = {length_accum_ff[23:0], b};
   assign num_shift  = {number_accum_ff[55:0], b};
   assign pairs_dec  = pairs_left_ff - 32'd1;

   // Next parse state.
   always_comb begin
      phase_in              = phase_ff;
      container_is_array_in = container_is_array_ff;
      field_remaining_in    = field_remaining_ff;
      length_accum_in       = length_accum_ff;
      number_accum_in       = number_accum_ff;
      pairs_left_in         = pairs_left_ff;
      pair_count_in         = pair_count_ff;
      vtype_in              = vtype_ff;
      byte_total_in         = byte_total_ff;
      do_finish             = 1'b0;
      if (start) begin
         byte_total_in   = 32'd1;
         pair_count_in   = 32'd0;
         pairs_left_in   = 32'd0;
         vtype_in        = VT_NONE;
         length_accum_in = 32'd0;
         number_accum_in = 64'd0;
         if (b == MK_OBJECT) begin
            container_is_array_in = 1'b0;
            phase_in              = PH_KEYLEN;
            field_remaining_in    = 32'd2;
         end else if (b == MK_MIXED) begin
            container_is_array_in = 1'b1;
            phase_in              = PH_COUNT;
            field_remaining_in    = 32'd4;
         end else begin
            phase_in = PH_IDLE;
         end
      end else if (active) begin
         byte_total_in = byte_total_ff + 32'd1;
         case (phase_ff)
            PH_COUNT: begin
               length_accum_in    = len_shift;
               field_remaining_in = field_dec;
               if (field_last) begin
                  pairs_left_in = len_shift;
                  if (len_shift == 32'd0) begin
                     phase_in           = PH_END;
                     field_remaining_in = ARRAY_END_BYTES;
                  end else begin
                     phase_in           = PH_KEYLEN;
                     field_remaining_in = 32'd2;
                     length_accum_in    = 32'd0;
                  end
               end
            end
            PH_KEYLEN: begin
               length_accum_in    = len_shift;
               field_remaining_in = field_dec;
               if (field_last) begin
                  if (len_shift == 32'd0) begin
                     if (container_is_array_ff) begin
                        phase_in = PH_VALTYPE;
                     end else begin
                        phase_in           = PH_END;
                        field_remaining_in = 32'd1;
                     end
                  end else begin
                     phase_in           = PH_KEY;
                     field_remaining_in = len_shift;
                  end
               end
            end
            PH_KEY: begin
               field_remaining_in = field_dec;
               if (field_last) begin
                  phase_in = PH_VALTYPE;
               end
            end
            PH_VALTYPE: begin
               number_accum_in = 64'd0;
               length_accum_in = 32'd0;
               case (b)
                  MK_NUMBER: begin
                     vtype_in           = VT_NUMBER;
                     phase_in           = PH_NUMBER;
                     field_remaining_in = 32'd8;
                  end
                  MK_BOOLEAN: begin
                     vtype_in           = VT_BOOLEAN;
                     phase_in           = PH_BOOL;
                     field_remaining_in = 32'd1;
                  end
                  MK_STRING: begin
                     vtype_in           = VT_STRING;
                     phase_in           = PH_STRLEN;
                     field_remaining_in = 32'd2;
                  end
                  MK_LONGSTR: begin
                     vtype_in           = VT_LONGSTR;
                     phase_in           = PH_STRLEN;
                     field_remaining_in = 32'd4;
                  end
                  default: begin
                     vtype_in = VT_NONE;
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            PH_NUMBER: begin
               number_accum_in    = num_shift;
               field_remaining_in = field_dec;
               do_finish          = field_last;
            end
            PH_BOOL: begin
               do_finish = 1'b1;
            end
            PH_STRLEN: begin
               length_accum_in    = len_shift;
               field_remaining_in = field_dec;
               if (field_last) begin
                  if (len_shift == 32'd0) begin
                     do_finish = 1'b1;
                  end else begin
                     phase_in           = PH_STR;
                     field_remaining_in = len_shift;
                  end
               end
            end
            PH_STR: begin
               field_remaining_in = field_dec;
               do_finish          = field_last;
            end
            PH_END: begin
               field_remaining_in = field_dec;
               if (field_last) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (do_finish) begin
            pair_count_in = pair_count_ff + 32'd1;
            vtype_in      = VT_NONE;
            if (container_is_array_ff) begin
               pairs_left_in = pairs_dec;
            end
            if (container_is_array_ff && (pairs_dec == 32'd0)) begin
               phase_in           = PH_END;
               field_remaining_in = ARRAY_END_BYTES;
            end else begin
               phase_in           = PH_KEYLEN;
               field_remaining_in = 32'd2;
               length_accum_in    = 32'd0;
            end
         end
      end else begin
         phase_in = PH_IDLE;
      end
   end

   // Result item for the byte on the input.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.kind = KIND_IGNORED;
      pair_byte = 1'b0;
      if (start) begin
         rsp_data_in.kind = KIND_CONTAINER;
         if ((b != MK_OBJECT) && (b != MK_MIXED)) begin
            rsp_data_in.error = ERR_CONTAINER;
            rsp_data_in.last  = 1'b1;
         end
      end else if (active) begin
         rsp_data_in.pair_index = pair_count_ff;
         case (phase_ff)
            PH_COUNT: begin
               rsp_data_in.kind      = KIND_COUNT;
               rsp_data_in.item_done = field_last;
               rsp_data_in.length    = field_last ? len_shift : 32'd0;
            end
            PH_KEYLEN: begin
               rsp_data_in.kind      = KIND_KEYLEN;
               rsp_data_in.item_done = field_last;
               rsp_data_in.length    = field_last ? len_shift : 32'd0;
               pair_byte = !(field_last && (len_shift == 32'd0) && !container_is_array_ff);
            end
            PH_KEY: begin
               rsp_data_in.kind      = KIND_KEY;
               rsp_data_in.data_byte = b;
               rsp_data_in.item_done = field_last;
               pair_byte = 1'b1;
            end
            PH_VALTYPE: begin
               rsp_data_in.kind = KIND_VALTYPE;
               pair_byte = 1'b1;
               case (b)
                  MK_NUMBER:  rsp_data_in.vtype = VT_NUMBER;
                  MK_BOOLEAN: rsp_data_in.vtype = VT_BOOLEAN;
                  MK_STRING:  rsp_data_in.vtype = VT_STRING;
                  MK_LONGSTR: rsp_data_in.vtype = VT_LONGSTR;
                  default: begin
                     rsp_data_in.vtype = VT_NONE;
                     rsp_data_in.error = ERR_VALTYPE;
                     rsp_data_in.last  = 1'b1;
                  end
               endcase
            end
            PH_NUMBER: begin
               rsp_data_in.kind        = KIND_NUMBER;
               rsp_data_in.vtype       = vtype_ff;
               rsp_data_in.item_done   = field_last;
               rsp_data_in.number_bits = field_last ? num_shift : 64'd0;
               pair_byte = 1'b1;
            end
            PH_BOOL: begin
               rsp_data_in.kind          = KIND_BOOL;
               rsp_data_in.vtype         = vtype_ff;
               rsp_data_in.boolean_value = (b != 8'd0);
               rsp_data_in.item_done     = 1'b1;
               pair_byte = 1'b1;
            end
            PH_STRLEN: begin
               rsp_data_in.kind      = KIND_STRLEN;
               rsp_data_in.vtype     = vtype_ff;
               rsp_data_in.item_done = field_last;
               rsp_data_in.length    = field_last ? len_shift : 32'd0;
               pair_byte = 1'b1;
            end
            PH_STR: begin
               rsp_data_in.kind      = KIND_STR;
               rsp_data_in.vtype     = vtype_ff;
               rsp_data_in.data_byte = b;
               rsp_data_in.item_done = field_last;
               pair_byte = 1'b1;
            end
            PH_END: begin
               rsp_data_in.kind = KIND_END;
               rsp_data_in.last = field_last;
            end
            default: begin
               rsp_data_in.kind = KIND_IGNORED;
            end
         endcase
      end
      rsp_data_in.stored     = pair_byte && (pair_count_ff < 32'(MAX_PAIRS));
      rsp_data_in.bytes_used = rsp_data_in.last ? byte_total_in : 32'd0;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff              <= PH_IDLE;
         container_is_array_ff <= 1'b0;
         field_remaining_ff    <= 32'd0;
         length_accum_ff       <= 32'd0;
         number_accum_ff       <= 64'd0;
         pairs_left_ff         <= 32'd0;
         pair_count_ff         <= 32'd0;
         vtype_ff              <= VT_NONE;
         byte_total_ff         <= 32'd0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff              <= phase_in;
            container_is_array_ff <= container_is_array_in;
            field_remaining_ff    <= field_remaining_in;
            length_accum_ff       <= length_accum_in;
            number_accum_ff       <= number_accum_in;
            pairs_left_ff         <= pairs_left_in;
            pair_count_ff         <= pair_count_in;
            vtype_ff              <= vtype_in;
            byte_total_ff         <= byte_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // An item that ends or aborts the container leaves the parser idle.
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_data_in.last |=> phase_ff == PH_IDLE)
      else $error("parser not idle after a final item");

   // Every error result also ends the container.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.error != ERR_NONE) |-> rsp_data_ff.last)
      else $error("error result without last");

   // The input side only stalls while a result is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_valid_ff && !rsp_chan.ready)
      else $error("input stalled without a held result");

   // Every accepted byte produces a result in the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted byte gave no result");

   // Only bytes of a key-value pair can be marked as stored.
   a_stored_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.stored |->
         (rsp_data_ff.kind == KIND_KEYLEN) || (rsp_data_ff.kind == KIND_KEY) ||
         (rsp_data_ff.kind == KIND_VALTYPE) || (rsp_data_ff.kind == KIND_NUMBER) ||
         (rsp_data_ff.kind == KIND_BOOL) || (rsp_data_ff.kind == KIND_STRLEN) ||
         (rsp_data_ff.kind == KIND_STR))
      else $error("stored flag on a byte outside a pair");

endmodule

### bench/tb_amf0_object_parser.sv
// Testbench for the AMF0 object parser: byte streams go in, and every classified byte that
// comes out is checked against a behavioral parser kept inside this bench or a scripted result.
// Depends on a0p_pkg, a0p_req_if, a0p_rsp_if and amf0_object_parser.
module tb_amf0_object_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import a0p_pkg::*;

   typedef struct packed {
      req_type stim;
      bit      typed;
      rsp_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   a0p_req_if req_chan ();
   a0p_rsp_if rsp_chan ();

   amf0_object_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   phase_type   parse_phase = PH_IDLE;
   bit          is_array    = 1'b0;
   logic [31:0] field_left  = '0;
   logic [31:0] len_acc     = '0;
   logic [63:0] num_acc     = '0;
   logic [31:0] pairs_to_go = '0;
   logic [31:0] pairs_done  = '0;
   logic [2:0]  cur_vtype   = VT_NONE;
   logic [31:0] byte_count  = '0;

   rsp_type        expected_rsp[$];
   req_type        pending[$];
   script_row_type script[$];
   int             mismatches = 0;
   int             bytes_fed  = 0;
   bit             req_steady = 1'b0;
   bit             rsp_steady = 1'b0;

   function automatic bit last_of_field();
      if (field_left <= 32'd1) begin
         field_left = '0;
         return 1'b1;
      end
      field_left = field_left - 32'd1;
      return 1'b0;
   endfunction

   task automatic enter_keylen();
      parse_phase = PH_KEYLEN;
      field_left  = 32'd2;
      len_acc     = '0;
   endtask

   task automatic enter_end();
      parse_phase = PH_END;
      field_left  = ARRAY_END_BYTES;
   endtask

   task automatic close_pair();
      pairs_done = pairs_done + 32'd1;
      cur_vtype  = VT_NONE;
      if (is_array) begin
         pairs_to_go = pairs_to_go - 32'd1;
         if (pairs_to_go == 0) begin
            enter_end();
            return;
         end
      end
      enter_keylen();
   endtask

   task automatic classify_byte(input req_type r, output rsp_type e);
      logic [7:0] b;
      bit         pair_byte;
      b         = r.in_byte;
      pair_byte = 1'b0;
      e         = '0;
      e.kind    = KIND_IGNORED;
      if (r.start_req) begin
         byte_count  = 32'd1;
         pairs_done  = '0;
         pairs_to_go = '0;
         cur_vtype   = VT_NONE;
         len_acc     = '0;
         num_acc     = '0;
         e.kind      = KIND_CONTAINER;
         if (b == MK_OBJECT) begin
            is_array = 1'b0;
            enter_keylen();
         end else if (b == MK_MIXED) begin
            is_array    = 1'b1;
            parse_phase = PH_COUNT;
            field_left  = 32'd4;
         end else begin
            e.error     = ERR_CONTAINER;
            e.last      = 1'b1;
            parse_phase = PH_IDLE;
         end
      end else if (parse_phase != PH_IDLE) begin
         byte_count   = byte_count + 32'd1;
         e.pair_index = pairs_done;
         case (parse_phase)
            PH_COUNT: begin
               e.kind  = KIND_COUNT;
               len_acc = {len_acc[23:0], b};
               if (last_of_field()) begin
                  e.item_done = 1'b1;
                  e.length    = len_acc;
                  pairs_to_go = len_acc;
                  if (len_acc == 0) enter_end();
                  else enter_keylen();
               end
            end
            PH_KEYLEN: begin
               e.kind    = KIND_KEYLEN;
               pair_byte = 1'b1;
               len_acc   = {len_acc[23:0], b};
               if (last_of_field()) begin
                  e.item_done = 1'b1;
                  e.length    = len_acc;
                  if (len_acc == 0) begin
                     if (is_array) begin
                        parse_phase = PH_VALTYPE;
                     end else begin
                        parse_phase = PH_END;
                        field_left  = 32'd1;
                        pair_byte   = 1'b0;
                     end
                  end else begin
                     parse_phase = PH_KEY;
                     field_left  = len_acc;
                  end
               end
            end
            PH_KEY: begin
               e.kind      = KIND_KEY;
               pair_byte   = 1'b1;
               e.data_byte = b;
               if (last_of_field()) begin
                  e.item_done = 1'b1;
                  parse_phase = PH_VALTYPE;
               end
            end
            PH_VALTYPE: begin
               e.kind    = KIND_VALTYPE;
               pair_byte = 1'b1;
               num_acc   = '0;
               len_acc   = '0;
               case (b)
                  MK_NUMBER: begin
                     cur_vtype   = VT_NUMBER;
                     parse_phase = PH_NUMBER;
                     field_left  = 32'd8;
                  end
                  MK_BOOLEAN: begin
                     cur_vtype   = VT_BOOLEAN;
                     parse_phase = PH_BOOL;
                     field_left  = 32'd1;
                  end
                  MK_STRING: begin
                     cur_vtype   = VT_STRING;
                     parse_phase = PH_STRLEN;
                     field_left  = 32'd2;
                  end
                  MK_LONGSTR: begin
                     cur_vtype   = VT_LONGSTR;
                     parse_phase = PH_STRLEN;
                     field_left  = 32'd4;
                  end
                  default: begin
                     cur_vtype   = VT_NONE;
                     e.error     = ERR_VALTYPE;
                     e.last      = 1'b1;
                     parse_phase = PH_IDLE;
                  end
               endcase
               e.vtype = cur_vtype;
            end
            PH_NUMBER: begin
               e.kind    = KIND_NUMBER;
               pair_byte = 1'b1;
               e.vtype   = cur_vtype;
               num_acc   = {num_acc[55:0], b};
               if (last_of_field()) begin
                  e.item_done   = 1'b1;
                  e.number_bits = num_acc;
                  close_pair();
               end
            end
            PH_BOOL: begin
               e.kind          = KIND_BOOL;
               pair_byte       = 1'b1;
               e.vtype         = cur_vtype;
               e.boolean_value = (b != 8'h00);
               e.item_done     = 1'b1;
               close_pair();
            end
            PH_STRLEN: begin
               e.kind    = KIND_STRLEN;
               pair_byte = 1'b1;
               e.vtype   = cur_vtype;
               len_acc   = {len_acc[23:0], b};
               if (last_of_field()) begin
                  e.item_done = 1'b1;
                  e.length    = len_acc;
                  if (len_acc == 0) begin
                     close_pair();
                  end else begin
                     parse_phase = PH_STR;
                     field_left  = len_acc;
                  end
               end
            end
            PH_STR: begin
               e.kind      = KIND_STR;
               pair_byte   = 1'b1;
               e.vtype     = cur_vtype;
               e.data_byte = b;
               if (last_of_field()) begin
                  e.item_done = 1'b1;
                  close_pair();
               end
            end
            default: begin
               e.kind = KIND_END;
               if (last_of_field()) begin
                  e.last      = 1'b1;
                  parse_phase = PH_IDLE;
               end
            end
         endcase
      end else begin
         parse_phase = PH_IDLE;
      end
      e.stored     = pair_byte && (e.pair_index < MAX_PAIRS);
      e.bytes_used = e.last ? byte_count : '0;
   endtask

   function automatic rsp_type outcome(input logic [3:0] kind, input logic stored,
                                       input logic [1:0] err, input logic [31:0] used);
      rsp_type r;
      r            = '0;
      r.kind       = kind;
      r.stored     = stored;
      r.error      = err;
      r.last       = (used != 0);
      r.bytes_used = used;
      return r;
   endfunction

   task automatic add_step(input logic [7:0] b, input bit s, input bit typed,
                           input rsp_type want);
      script_row_type row;
      row.stim.in_byte   = b;
      row.stim.start_req = s;
      row.typed          = typed;
      row.want           = want;
      script.push_back(row);
   endtask

   task automatic put(input logic [7:0] b, input bit s);
      req_type r;
      r.in_byte   = b;
      r.start_req = s;
      pending.push_back(r);
   endtask

   task automatic put_field(input logic [31:0] value, input int nbytes);
      for (int k = nbytes - 1; k >= 0; k--) put(value[8*k +: 8], 1'b0);
   endtask

   task automatic compose_container();
      int         shape, npairs, klen, slen, vsel, fill, first, cut;
      logic [7:0] b;
      bit         arr;
      first = pending.size();
      shape = $urandom_range(0, 99);
      if (shape < 4) begin
         do b = 8'($urandom); while (b == MK_OBJECT || b == MK_MIXED);
         put(b, 1'b1);
      end else if (shape < 10) begin
         put($urandom_range(0, 1) ? MK_OBJECT : MK_MIXED, 1'b1);
         repeat ($urandom_range(4, 24)) put(8'($urandom), 1'b0);
      end else if (shape < 15) begin
         repeat ($urandom_range(1, 4)) put(8'($urandom), 1'b0);
      end else begin
         arr    = 1'($urandom_range(0, 1));
         npairs = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_PAIRS - 2, MAX_PAIRS + 3)
                                               : $urandom_range(0, 4);
         put(arr ? MK_MIXED : MK_OBJECT, 1'b1);
         if (arr) put_field(npairs, 4);
         for (int i = 0; i < npairs; i++) begin
            klen = $urandom_range(arr ? 0 : 1, 3);
            put_field(klen, 2);
            repeat (klen) put(8'($urandom), 1'b0);
            vsel = $urandom_range(0, 19);
            if (vsel == 0) begin
               do b = 8'($urandom);
               while (b == MK_NUMBER || b == MK_BOOLEAN || b == MK_STRING || b == MK_LONGSTR);
               put(b, 1'b0);
               return;
            end else if (vsel < 6) begin
               put(MK_NUMBER, 1'b0);
               fill = $urandom_range(0, 3);
               repeat (8) put(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom), 1'b0);
            end else if (vsel < 11) begin
               put(MK_BOOLEAN, 1'b0);
               put($urandom_range(0, 1) ? 8'h00 : 8'($urandom), 1'b0);
            end else begin
               slen = $urandom_range(0, 4);
               put(vsel < 16 ? MK_STRING : MK_LONGSTR, 1'b0);
               put_field(slen, vsel < 16 ? 2 : 4);
               repeat (slen) put(8'($urandom), 1'b0);
            end
         end
         if (arr) begin
            repeat (3) put(8'($urandom), 1'b0);
         end else begin
            put_field(0, 2);
            put(8'($urandom), 1'b0);
         end
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(first + 1, pending.size() - 1);
            while (pending.size() > cut) void'(pending.pop_back());
         end
      end
   endtask

   task automatic feed_byte(input req_type r, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = req_steady ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 63) == 0) req_steady = !req_steady;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      classify_byte(r, predicted);
      if (predicted.kind != KIND_IGNORED) bytes_fed++;
      expected_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic match_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   initial begin : result_sink
      int      stall;
      rsp_type got;
      rsp_type want;
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 7);
         if ($urandom_range(0, 63) == 0) rsp_steady = !rsp_steady;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         got = rsp_chan.payload;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            $display("%0t unexpected item: expected none, actual %0h", $time, got);
         end else begin
            want = expected_rsp.pop_front();
            match_field("kind", 64'(want.kind), 64'(got.kind));
            match_field("pair_index", 64'(want.pair_index), 64'(got.pair_index));
            match_field("vtype", 64'(want.vtype), 64'(got.vtype));
            match_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
            match_field("number_bits", want.number_bits, got.number_bits);
            match_field("boolean_value", 64'(want.boolean_value), 64'(got.boolean_value));
            match_field("length", 64'(want.length), 64'(got.length));
            match_field("item_done", 64'(want.item_done), 64'(got.item_done));
            match_field("stored", 64'(want.stored), 64'(got.stored));
            match_field("error", 64'(want.error), 64'(got.error));
            match_field("last", 64'(want.last), 64'(got.last));
            match_field("bytes_used", 64'(want.bytes_used), 64'(got.bytes_used));
         end
      end
   end

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_step(8'hFF, 1'b0, 1'b1, outcome(KIND_IGNORED, 1'b0, ERR_NONE, 32'd0));
      add_step(8'hFF, 1'b1, 1'b1, outcome(KIND_CONTAINER, 1'b0, ERR_CONTAINER, 32'd1));
      add_step(MK_MIXED, 1'b1, 1'b1, outcome(KIND_CONTAINER, 1'b0, ERR_NONE, 32'd0));
      repeat (4) add_step(8'h00, 1'b0, 1'b0, '0);
      add_step(8'hFF, 1'b0, 1'b0, '0);
      add_step(8'h00, 1'b0, 1'b0, '0);
      add_step(8'hFF, 1'b0, 1'b1, outcome(KIND_END, 1'b0, ERR_NONE, 32'd8));
      add_step(MK_OBJECT, 1'b1, 1'b0, '0);
      add_step(8'h00, 1'b0, 1'b0, '0);
      add_step(8'h01, 1'b0, 1'b0, '0);
      add_step(8'hFF, 1'b0, 1'b0, '0);
      add_step(MK_LONGSTR, 1'b0, 1'b0, '0);
      repeat (4) add_step(8'h00, 1'b0, 1'b0, '0);
      repeat (2) add_step(8'h00, 1'b0, 1'b0, '0);
      add_step(8'hAA, 1'b0, 1'b0, '0);
      add_step(MK_MIXED, 1'b1, 1'b0, '0);
      repeat (3) add_step(8'h00, 1'b0, 1'b0, '0);
      add_step(8'h01, 1'b0, 1'b0, '0);
      repeat (2) add_step(8'h00, 1'b0, 1'b0, '0);
      add_step(8'h07, 1'b0, 1'b1, outcome(KIND_VALTYPE, 1'b1, ERR_VALTYPE, 32'd8));

      foreach (script[i]) feed_byte(script[i].stim, script[i].typed, script[i].want);

      while (bytes_fed < 1850) begin
         compose_container();
         while (pending.size() != 0) feed_byte(pending.pop_front(), 1'b0, '0);
      end

      req_chan.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("[amf0_object_parser] OK");
      else $display("[amf0_object_parser] ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[amf0_object_parser] ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/a0p_pkg.sv
rtl/a0p_req_if.sv
rtl/a0p_rsp_if.sv
rtl/amf0_object_parser.sv
bench/tb_amf0_object_parser.sv
